FILE: rtl/bmd_pkg.sv
// ----------------------------------------------------------------------------
// bmd_pkg: shared types and constants of the block median downsampler
// Block geometry, frame limits, register indexes and channel payload types.
// ----------------------------------------------------------------------------
package bmd_pkg;

  localparam int BLOCK_SIZE   = 4;
  localparam int MAX_WIDTH    = 512;
  localparam int HEIGHT_LIMIT = 512;
  localparam int STORE_ROWS   = BLOCK_SIZE - 1;
  localparam int BLOCK_AREA   = BLOCK_SIZE * BLOCK_SIZE;
  localparam int WORDS        = MAX_WIDTH / BLOCK_SIZE;

  localparam int PIX_W  = 16;
  localparam int DIM_W  = 10;
  localparam int POS_W  = 9;
  localparam int SUB_W  = $clog2(BLOCK_SIZE);
  localparam int ADDR_W = $clog2(WORDS);
  localparam int CNT_W  = $clog2(BLOCK_AREA + 1);
  localparam int WORD_W = PIX_W * BLOCK_SIZE;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(512);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(424);
  localparam logic [DIM_W-1:0] DIM_MIN      = DIM_W'(BLOCK_SIZE);
  localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(HEIGHT_LIMIT);

  typedef enum logic [0:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [PIX_W-1:0] depth_mm;
    logic             start_of_frame;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] median_depth;
    logic             block_has_data;
    logic             end_of_out_row;
    logic             end_of_out_frame;
  } out_item_t;

  typedef struct packed {
    logic eor;
    logic eof;
  } blk_flags_t;

endpackage

FILE: rtl/bmd_in_if.sv
// ----------------------------------------------------------------------------
// bmd_in_if: pixel request channel
// Valid/ready channel that carries one depth pixel per request.
// ----------------------------------------------------------------------------
interface bmd_in_if;
  logic              valid;
  logic              ready;
  bmd_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/bmd_out_if.sv
// ----------------------------------------------------------------------------
// bmd_out_if: block result channel
// Valid/ready channel that carries one block median per request.
// ----------------------------------------------------------------------------
interface bmd_out_if;
  logic               valid;
  logic               ready;
  bmd_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/block_median_downsample.sv
// ----------------------------------------------------------------------------
// block_median_downsample: masked 4x4 median downsampler
// Reduces each 4x4 block of a raster depth stream to the upper median of
// its nonzero samples, using a row store for the upper rows of a band.
// ----------------------------------------------------------------------------
// channel   dir  payload
// in_ch     in   depth_mm, start_of_frame
// out_ch    out  median_depth, block_has_data, end_of_out_row, end_of_out_frame
// cfg_*     in   frame_width (0), frame_height (1)
//
// One pixel is accepted per cycle unless the output stalls. The pixel that
// completes a block passes through gather, rank compare and select registers.
// The pipeline stalls as a whole while a result waits on the output.
// Reset is synchronous; the row store is not cleared.
// ----------------------------------------------------------------------------
module block_median_downsample (
  input  logic                       clk,
  input  logic                       rst_n,
  bmd_in_if.sink                     in_ch,
  bmd_out_if.source                  out_ch,
  input  logic                       cfg_wr_en,
  input  bmd_pkg::cfg_index_t        cfg_index,
  input  logic [bmd_pkg::DIM_W-1:0]  cfg_data
);

  localparam int N  = bmd_pkg::BLOCK_AREA;
  localparam int BS = bmd_pkg::BLOCK_SIZE;
  localparam int SR = bmd_pkg::STORE_ROWS;

  logic [bmd_pkg::DIM_W-1:0] width_r, height_r, used_w_r, used_h_r;
  logic [bmd_pkg::DIM_W-1:0] dim_clamp;
  logic [bmd_pkg::POS_W-1:0] col_r, row_r, col_nxt, row_nxt;
  logic [bmd_pkg::POS_W-1:0] col_cur, row_cur;
  logic [bmd_pkg::SUB_W-1:0] sub_c, sub_r;
  logic [bmd_pkg::ADDR_W-1:0] addr;
  logic [bmd_pkg::PIX_W-1:0] lane_r [SR];
  logic [bmd_pkg::WORD_W-1:0] rd_r [SR];
  logic advance, accept, blk_done, wr_en, rd_en;
  bmd_pkg::blk_flags_t flags_nxt, s1_flags_r, s2_flags_r;
  logic [bmd_pkg::PIX_W-1:0] gather [N];
  logic [bmd_pkg::PIX_W-1:0] s1_vals_r [N];
  logic [bmd_pkg::PIX_W-1:0] s2_vals_r [N];
  logic [N-1:0] s1_mask_r, s2_mask_r;
  logic [N-1:0] lt_nxt [N];
  logic [N-1:0] s2_lt_r [N];
  logic [bmd_pkg::CNT_W-1:0] s2_cnt_r;
  logic s1_valid_r, s2_valid_r, out_valid_r;
  bmd_pkg::out_item_t out_r, out_nxt;

  assign advance = !out_valid_r || out_ch.ready;
  assign accept  = in_ch.valid && advance;
  assign in_ch.ready  = advance;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  always_comb begin
    if (cfg_data < bmd_pkg::DIM_MIN) begin
      dim_clamp = bmd_pkg::DIM_MIN;
    end else if (cfg_index == bmd_pkg::CFG_FRAME_WIDTH && cfg_data > bmd_pkg::WIDTH_MAX) begin
      dim_clamp = bmd_pkg::WIDTH_MAX;
    end else if (cfg_index == bmd_pkg::CFG_FRAME_HEIGHT && cfg_data > bmd_pkg::HEIGHT_MAX) begin
      dim_clamp = bmd_pkg::HEIGHT_MAX;
    end else begin
      dim_clamp = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= bmd_pkg::WIDTH_RESET;
      height_r <= bmd_pkg::HEIGHT_RESET;
      used_w_r <= bmd_pkg::WIDTH_RESET & ~bmd_pkg::DIM_W'(BS - 1);
      used_h_r <= bmd_pkg::HEIGHT_RESET & ~bmd_pkg::DIM_W'(BS - 1);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bmd_pkg::CFG_FRAME_WIDTH: begin
          width_r  <= dim_clamp;
          used_w_r <= dim_clamp & ~bmd_pkg::DIM_W'(BS - 1);
        end
        bmd_pkg::CFG_FRAME_HEIGHT: begin
          height_r <= dim_clamp;
          used_h_r <= dim_clamp & ~bmd_pkg::DIM_W'(BS - 1);
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    col_cur = in_ch.data.start_of_frame ? '0 : col_r;
    row_cur = in_ch.data.start_of_frame ? '0 : row_r;
    sub_c   = col_cur[bmd_pkg::SUB_W-1:0];
    sub_r   = row_cur[bmd_pkg::SUB_W-1:0];
    addr    = col_cur[bmd_pkg::POS_W-1:bmd_pkg::SUB_W];
    wr_en   = accept && (sub_r != bmd_pkg::SUB_W'(BS - 1));
    rd_en   = accept && (sub_r == bmd_pkg::SUB_W'(BS - 1)) && (sub_c == '0);
    blk_done = (sub_r == bmd_pkg::SUB_W'(BS - 1)) && (sub_c == bmd_pkg::SUB_W'(BS - 1))
               && ({1'b0, col_cur} < used_w_r) && ({1'b0, row_cur} < used_h_r);
    flags_nxt.eor = ({1'b0, col_cur} + 1'b1) == used_w_r;
    flags_nxt.eof = flags_nxt.eor && (({1'b0, row_cur} + 1'b1) == used_h_r);
    if (({1'b0, col_cur} + 1'b1) >= width_r) begin
      col_nxt = '0;
      row_nxt = (({1'b0, row_cur} + 1'b1) >= height_r) ? '0 : row_cur + 1'b1;
    end else begin
      col_nxt = col_cur + 1'b1;
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int k = 0; k < SR; k++) begin
        lane_r[k] <= '0;
      end
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      for (int k = 0; k < SR; k++) begin
        if (sub_c == bmd_pkg::SUB_W'(k)) begin
          lane_r[k] <= in_ch.data.depth_mm;
        end
      end
    end
  end

  for (genvar g = 0; g < SR; g++) begin : g_row
    logic [bmd_pkg::WORD_W-1:0] mem [bmd_pkg::WORDS];

    always_ff @(posedge clk) begin
      if (wr_en && sub_r == bmd_pkg::SUB_W'(g)) begin
        mem[addr][sub_c*bmd_pkg::PIX_W +: bmd_pkg::PIX_W] <= in_ch.data.depth_mm;
      end
      if (rd_en) begin
        rd_r[g] <= mem[addr];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < SR; i++) begin
      for (int j = 0; j < BS; j++) begin
        gather[i*BS + j] = rd_r[i][j*bmd_pkg::PIX_W +: bmd_pkg::PIX_W];
      end
    end
    for (int j = 0; j < SR; j++) begin
      gather[SR*BS + j] = lane_r[j];
    end
    gather[N-1] = in_ch.data.depth_mm;
  end

  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        lt_nxt[i][j] = s1_mask_r[j] && ((s1_vals_r[j] < s1_vals_r[i])
                       || ((s1_vals_r[j] == s1_vals_r[i]) && (j < i)));
      end
    end
  end

  always_comb begin
    out_nxt = '0;
    for (int i = 0; i < N; i++) begin
      if (s2_mask_r[i] && (bmd_pkg::CNT_W'($countones(s2_lt_r[i])) == (s2_cnt_r >> 1))) begin
        out_nxt.median_depth = out_nxt.median_depth | s2_vals_r[i];
      end
    end
    out_nxt.block_has_data   = |s2_mask_r;
    out_nxt.end_of_out_row   = s2_flags_r.eor;
    out_nxt.end_of_out_frame = s2_flags_r.eof;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r  <= accept && blk_done;
      s2_valid_r  <= s1_valid_r;
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int i = 0; i < N; i++) begin
        s1_vals_r[i] <= gather[i];
        s1_mask_r[i] <= gather[i] != '0;
        s2_vals_r[i] <= s1_vals_r[i];
        s2_lt_r[i]   <= lt_nxt[i];
      end
      s1_flags_r <= flags_nxt;
      s2_flags_r <= s1_flags_r;
      s2_mask_r  <= s1_mask_r;
      s2_cnt_r   <= bmd_pkg::CNT_W'($countones(s1_mask_r));
      out_r      <= out_nxt;
    end
  end

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.block_has_data |-> out_r.median_depth == '0)
    else $error("empty block with nonzero median");

  a_eof_eor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.end_of_out_frame |-> out_r.end_of_out_row)
    else $error("frame end without row end");

  a_block_enters: assert property (@(posedge clk) disable iff (!rst_n)
    accept && blk_done |=> s1_valid_r)
    else $error("completed block not captured");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(wr_en && rd_en))
    else $error("row store read and write in one cycle");

endmodule
